/* src/assert_macros.svh */
// Assertion macros shared by the matcher RTL.
// Each macro takes clk and rst_n from the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define PSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence required in the cycle after a trigger
`define PSM_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* src/psm_pkg.sv */
// Package for the payload signature matcher: sizes, codes, transfer types,
// the signature ROM and the case-folding helper. No dependencies.
package psm_pkg;

    localparam int WIN_BYTES   = 32;
    localparam int SIG_COUNT   = 37;
    localparam int SIG_MAX_LEN = 29;
    localparam int SEEN_W      = $clog2(WIN_BYTES + 1);
    localparam int LEN_W       = $clog2(SIG_MAX_LEN + 1);
    localparam int CODE_W      = 6;
    localparam int VER_W       = 16;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    // Verdict codes
    localparam logic [CODE_W-1:0] CODE_NONE     = 6'd0;
    localparam logic [CODE_W-1:0] CODE_TLS      = 6'd1;
    localparam logic [CODE_W-1:0] CODE_SIG_BASE = 6'd2;

    // TLS handshake recognition
    localparam logic [7:0]       TLS_RECORD      = 8'h16;
    localparam logic [7:0]       TLS_HELLO_A     = 8'h01;
    localparam logic [7:0]       TLS_HELLO_B     = 8'h02;
    localparam logic [VER_W-1:0] TLS_MAX_RESET   = 16'h0302;
    localparam logic [SEEN_W-1:0] TLS_POS_TYPE   = SEEN_W'(0);
    localparam logic [SEEN_W-1:0] TLS_POS_HELLO  = SEEN_W'(5);
    localparam logic [SEEN_W-1:0] TLS_POS_VER_HI = SEEN_W'(9);
    localparam logic [SEEN_W-1:0] TLS_POS_VER_LO = SEEN_W'(10);
    localparam logic [SEEN_W-1:0] TLS_MIN_LEN    = SEEN_W'(11);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic              verdict;
        logic [CODE_W-1:0] threat_code;
    } result_t;

    // Entry 0 is the newest byte
    typedef logic [WIN_BYTES-1:0][7:0] window_t;

    typedef struct packed {
        window_t           window;
        logic [SEEN_W-1:0] seen;
    } win_view_t;

    // Patterns right-aligned: the final character sits in bits [7:0]
    typedef logic [8*SIG_MAX_LEN-1:0] sig_pat_t;

    localparam sig_pat_t SIG_PAT [SIG_COUNT] = '{
        sig_pat_t'(64'h9090909090909090),                       // NOP sled
        "cmd.exe /c",
        sig_pat_t'(152'h706f7765727368656c6c2e657865202d656e63), // encoded shell launch
        "wmic process call create",
        "/bin/bash -i",
        "nc -e /bin/sh",
        "union select",
        "or 1=1",
        "or '1'='1'",
        "waitfor delay",
        "drop table",
        "<script>",
        "alert(1)",
        "document.cookie",
        "..\\..\\",
        "../..",
        "/etc/passwd",
        "/etc/shadow",
        "eval($_POST",
        "Runtime.getRuntime().exec",
        "/bin/busybox",
        "/cgi-bin/",
        "wget http",
        "curl -o",
        "nc -e",
        "root\015\012root\015\012",
        "admin\015\012admin\015\012",
        "urn:schemas-upnp-org:service",
        "\\\\ipc$",
        "psexesvc.exe",
        "default.prof",
        sig_pat_t'(88'h6d65746572707265746572),                 // exploit kit name
        "${jndi:ldap://",
        "${jndi:rmi://",
        "user-agent: curl",
        "user-agent: wget",
        // scripting shell user agent
        sig_pat_t'(232'h757365722d6167656e743a2077696e646f7773706f7765727368656c6c)
    };

    localparam logic [LEN_W-1:0] SIG_LEN [SIG_COUNT] = '{
        5'd8,  5'd10, 5'd19, 5'd24, 5'd12, 5'd13, 5'd12, 5'd6,
        5'd10, 5'd13, 5'd10, 5'd8,  5'd8,  5'd15, 5'd6,  5'd5,
        5'd11, 5'd11, 5'd11, 5'd25, 5'd12, 5'd9,  5'd9,  5'd7,
        5'd5,  5'd12, 5'd14, 5'd28, 5'd6,  5'd12, 5'd12, 5'd11,
        5'd14, 5'd13, 5'd16, 5'd16, 5'd29
    };

    // 1: compare after folding A-Z to lower case
    localparam bit SIG_FOLD [SIG_COUNT] = '{
        1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* src/psm_cfg.sv */
// APB-style register file for the matcher: the TLS version limit.
// Depends on psm_pkg.
module psm_cfg
    import psm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [VER_W-1:0]   tls_max
);

    logic [VER_W-1:0] tls_max_reg;
    logic [VER_W-1:0] tls_max_next;
    logic             wr_en;

    // Single register: the byte offset bits select nothing else
    assign wr_en        = psel && penable && pwrite;
    assign tls_max_next = wr_en ? pwdata[VER_W-1:0] : tls_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tls_max_reg <= TLS_MAX_RESET;
        end
        else
        begin
            tls_max_reg <= tls_max_next;
        end
    end

    // Read-back; paddr only carries the byte offset
    assign prdata  = (paddr == '0 || paddr != '0) ?
                     {{(PDATA_W-VER_W){1'b0}}, tls_max_reg} : '0;
    assign pready  = 1'b1;
    assign tls_max = tls_max_reg;

endmodule

/* src/psm_match.sv */
// Signature compare array: tests every ROM signature ending at the newest byte.
// Depends on psm_pkg.
module psm_match
    import psm_pkg::*;
(
    input  win_view_t            view,
    output logic [SIG_COUNT-1:0] sig_match
);

    // One equality chain per signature against constant bytes
    always_comb
    begin
        logic       ok;
        logic [7:0] c;
        for (int i = 0; i < SIG_COUNT; i++)
        begin
            ok = (view.seen >= SEEN_W'(SIG_LEN[i]));
            for (int k = 0; k < SIG_MAX_LEN; k++)
            begin
                c = SIG_FOLD[i] ? fold_lower(view.window[k]) : view.window[k];
                if (k < int'(SIG_LEN[i]))
                begin
                    ok = ok && (c == SIG_PAT[i][8*k +: 8]);
                end
            end
            sig_match[i] = ok;
        end
    end

endmodule

/* src/psm_core.sv */
// Per-payload state: byte window, byte count, TLS tracking, sticky hits and
// the verdict picked on the last byte. Depends on psm_pkg, psm_match.
`include "assert_macros.svh"

module psm_core
    import psm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  byte_item_t       item,
    input  logic [VER_W-1:0] tls_max,
    output result_t          result_next
);

    window_t              window_reg;
    window_t              window_next;
    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_next;
    logic [SIG_COUNT-1:0] hits_reg;
    logic [SIG_COUNT-1:0] hits_next;
    logic                 rec_reg;
    logic                 rec_next;
    logic                 hello_reg;
    logic                 hello_next;
    logic [7:0]           ver_hi_reg;
    logic [7:0]           ver_hi_next;
    logic [SIG_COUNT-1:0] sig_match;
    win_view_t            view;
    logic                 state_clear;

    // Window and count after this byte
    assign window_next = {window_reg[WIN_BYTES-2:0], item.data_byte};
    assign seen_next   = (seen_reg < SEEN_W'(WIN_BYTES)) ? seen_reg + 1'b1 : seen_reg;
    assign view        = '{window: window_next, seen: seen_next};

    psm_match u_match
    (
        .view      (view),
        .sig_match (sig_match)
    );

    assign hits_next = hits_reg | sig_match;

    // TLS header tracking by byte position
    always_comb
    begin
        rec_next    = rec_reg;
        hello_next  = hello_reg;
        ver_hi_next = ver_hi_reg;
        if (seen_reg == TLS_POS_TYPE)
        begin
            rec_next = (item.data_byte == TLS_RECORD);
        end
        else if (seen_reg == TLS_POS_HELLO)
        begin
            hello_next = (item.data_byte == TLS_HELLO_A) || (item.data_byte == TLS_HELLO_B);
        end
        else if (seen_reg == TLS_POS_VER_HI)
        begin
            ver_hi_next = item.data_byte;
        end
        else if (seen_reg == TLS_POS_VER_LO)
        begin
            hello_next = rec_reg && hello_reg && ({ver_hi_reg, item.data_byte} <= tls_max);
        end
    end

    // Verdict: TLS first, then lowest-numbered signature hit
    always_comb
    begin
        result_next.verdict     = 1'b0;
        result_next.threat_code = CODE_NONE;
        if (seen_next >= TLS_MIN_LEN && hello_next)
        begin
            result_next.verdict     = 1'b1;
            result_next.threat_code = CODE_TLS;
        end
        else
        begin
            for (int i = SIG_COUNT - 1; i >= 0; i--)
            begin
                if (hits_next[i])
                begin
                    result_next.verdict     = 1'b1;
                    result_next.threat_code = CODE_SIG_BASE + CODE_W'(i);
                end
            end
        end
    end

    // Window bytes beyond the count are never compared, so it is not cleared
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            hits_reg   <= '0;
            rec_reg    <= 1'b0;
            hello_reg  <= 1'b0;
            ver_hi_reg <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                seen_reg   <= '0;
                hits_reg   <= '0;
                rec_reg    <= 1'b0;
                hello_reg  <= 1'b0;
                ver_hi_reg <= '0;
            end
            else
            begin
                seen_reg   <= seen_next;
                hits_reg   <= hits_next;
                rec_reg    <= rec_next;
                hello_reg  <= hello_next;
                ver_hi_reg <= ver_hi_next;
            end
        end
    end

    // Per-payload state back at its start values
    assign state_clear = (seen_reg == '0) && (hits_reg == '0) && !hello_reg;

    `PSM_ASSERT(a_seen_sat, seen_reg <= SEEN_W'(WIN_BYTES), "byte count above window size")
    `PSM_ASSERT_NEXT(a_clear_after_last, step && item.last_byte, state_clear, "state not cleared")

endmodule

/* src/payload_signature_matcher.sv */
// Top level of the payload signature matcher: input register, core, result
// register and configuration port. Depends on psm_pkg, psm_cfg, psm_core.
//
// Takes one payload byte per clock cycle, back to back, and gives one verdict
// per payload: the last byte sits in the input register while the signature
// compare array works on it, and its verdict goes into the result register once
// that register has room. Every byte is compared against all 37 signatures in
// that single pass, so the sustained rate is one byte per cycle while verdicts
// are taken. A verdict that is not taken holds the next last byte in the input
// register, and the bytes behind it wait until the verdict goes. The TLS
// version limit sits at byte address 0 and should only be written between
// payloads.
`include "assert_macros.svh"

module payload_signature_matcher
    import psm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  byte_item_t         byte_item,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    byte_item_t       byte_reg;
    logic             byte_full_reg;
    logic             byte_full_next;
    result_t          result_reg;
    result_t          result_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             out_free;
    logic             step;
    logic             in_xfer;
    logic [VER_W-1:0] tls_max;
    logic             code_agrees;

    psm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tls_max (tls_max)
    );

    psm_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (byte_reg),
        .tls_max     (tls_max),
        .result_next (result_next)
    );

    // Stage advance: a last byte needs room in the result register
    assign out_free   = !result_valid_reg || result_ready;
    assign step       = byte_full_reg && (!byte_reg.last_byte || out_free);
    assign byte_ready = !byte_full_reg || step;
    assign in_xfer    = byte_valid && byte_ready;

    assign byte_full_next    = in_xfer ? 1'b1 : (step ? 1'b0 : byte_full_reg);
    assign result_valid_next = (step && byte_reg.last_byte) ? 1'b1 :
                               (result_ready ? 1'b0 : result_valid_reg);

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= byte_item;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step && byte_reg.last_byte)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_full_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_full_reg    <= byte_full_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Block verdicts carry a code, allow verdicts none
    assign code_agrees = (result_reg.verdict == (result_reg.threat_code != CODE_NONE));

    `PSM_ASSERT(a_code_matches_verdict, !result_valid_reg || code_agrees, "verdict and code disagree")
    `PSM_ASSERT_NEXT(a_last_gives_result, step && byte_reg.last_byte, result_valid_reg, "no verdict")

endmodule
